[sv/vq_texture_decoder_macros.svh]
// Assertion macros for the VQ texture decoder RTL.
// Uses the clk and rst names of the including module; no other dependencies.
`ifndef VQ_TEXTURE_DECODER_MACROS_SVH
`define VQ_TEXTURE_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define VQTD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define VQTD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define VQTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VQTD_ASSERT_ALWAYS(lbl, expr, msg)
`define VQTD_ASSERT_IMPLY(lbl, ante, cons, msg)
`define VQTD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[sv/vqtd_pkg.sv]
// Shared types, codes and the colour expansion function of the VQ texture decoder.
// No dependencies.
`default_nettype none
package vqtd_pkg;

  localparam int CODEBOOK_ENTRIES_DEF = 256;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;

  // item kinds
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // configuration register indexes
  localparam logic REG_PIXEL_FORMAT   = 1'b0;
  localparam logic REG_SMALL_CODEBOOK = 1'b1;

  // pixel formats
  localparam logic [1:0] FMT_ARGB1555 = 2'd0;
  localparam logic [1:0] FMT_RGB565   = 2'd1;
  localparam logic [1:0] FMT_ARGB4444 = 2'd2;

  typedef struct packed {
    logic       capture;  // latch code byte of an accepted decode
    logic       write;    // codebook word load
    logic       issue;    // codebook read for one texel
    logic [2:0] sel;      // {nibble group, column, row bit}
    logic       last;     // final texel of the code
  } cmd_t;

  typedef struct packed {
    logic can_issue;
    logic small_cb;
  } stat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic       last;
    logic [1:0] row;
    logic       column;
    rgb_t       rgb;
  } texel_t;

  function automatic rgb_t expand(input logic [1:0] fmt, input logic [15:0] c);
    rgb_t o;
    case (fmt)
      FMT_ARGB1555: begin
        o.red   = {c[14:10], 3'b000};
        o.green = {c[9:5], 3'b000};
        o.blue  = {c[4:0], 3'b000};
      end
      FMT_ARGB4444: begin
        o.red   = {c[11:8], 4'b0000};
        o.green = {c[7:4], 4'b0000};
        o.blue  = {c[3:0], 4'b0000};
      end
      default: begin
        // RGB565, also the unused format code
        o.red   = {c[15:11], 3'b000};
        o.green = {c[10:5], 2'b00};
        o.blue  = {c[4:0], 3'b000};
      end
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

[sv/vqtd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module vqtd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire  logic                     clk,
  input  wire  logic                     we,
  input  wire  logic [$clog2(DEPTH)-1:0] waddr,
  input  wire  logic [WIDTH-1:0]         wdata,
  input  wire  logic                     re,
  input  wire  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[sv/vqtd_ctrl.sv]
// Controller of the VQ texture decoder: input handshake and texel sequencing.
// Depends on vqtd_pkg and vq_texture_decoder_macros.svh.
`default_nettype none
`include "vq_texture_decoder_macros.svh"
module vqtd_ctrl (
  input  wire  logic          clk,
  input  wire  logic          rst,
  input  wire  logic          s_tvalid,
  input  wire  logic          s_tuser,
  output logic                s_tready,
  input  wire  vqtd_pkg::stat_t stat,
  output vqtd_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  localparam logic [2:0] SEL_END_NORMAL = 3'd3;
  localparam logic [2:0] SEL_END_SMALL  = 3'd7;

  state_t     state, state_next;
  logic [2:0] cnt, cnt_next;
  logic       small_q, small_q_next;

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    small_q_next = small_q;
    s_tready     = (state == ST_IDLE);
    cmd          = '0;
    cmd.sel      = cnt;
    cmd.last     = (cnt == (small_q ? SEL_END_SMALL : SEL_END_NORMAL));
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == vqtd_pkg::MODE_LOAD) begin
            cmd.write = 1'b1;
          end else begin
            cmd.capture  = 1'b1;
            state_next   = ST_RUN;
            cnt_next     = '0;
            small_q_next = stat.small_cb;
          end
        end
      end
      ST_RUN: begin
        cmd.issue = stat.can_issue;
        if (stat.can_issue) begin
          if (cmd.last) begin
            state_next = ST_IDLE;
          end else begin
            cnt_next = cnt + 3'd1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      small_q <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      small_q <= small_q_next;
    end
  end

  `VQTD_ASSERT_IMPLY(a_no_read_when_full, cmd.issue, stat.can_issue, "read without room")
  `VQTD_ASSERT_IMPLY(a_idle_no_read, state == ST_IDLE, !cmd.issue, "read issued while idle")
  `VQTD_ASSERT_NEXT(a_last_ends_run, cmd.issue && cmd.last, state == ST_IDLE, "run did not end")
  `VQTD_ASSERT_IMPLY(a_normal_range, state == ST_RUN && !small_q, !cnt[2], "count past four")

endmodule
`default_nettype wire

[sv/vqtd_datapath.sv]
// Datapath of the VQ texture decoder: configuration registers, codebook RAM,
// colour expansion and the two-entry output buffer. Depends on vqtd_pkg, vqtd_ram, macros.
`default_nettype none
`include "vq_texture_decoder_macros.svh"
module vqtd_datapath #(
  parameter int CODEBOOK_ENTRIES = vqtd_pkg::CODEBOOK_ENTRIES_DEF
) (
  input  wire  logic                                 clk,
  input  wire  logic                                 rst,
  input  wire  logic [vqtd_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  wire  logic                                 cfg_valid,
  input  wire  logic                                 cfg_index,
  input  wire  logic [1:0]                           cfg_data,
  input  wire  vqtd_pkg::cmd_t                       cmd,
  output vqtd_pkg::stat_t                            stat,
  output logic                                       m_tvalid,
  input  wire  logic                                 m_tready,
  output logic [vqtd_pkg::OUT_TDATA_W-1:0]           m_tdata,
  output logic                                       m_tlast
);

  localparam int EW    = $clog2(CODEBOOK_ENTRIES);
  localparam int AW    = EW + 2;
  localparam int DEPTH = CODEBOOK_ENTRIES * 4;
  localparam logic [8:0] ENTRY_LIMIT = 9'(CODEBOOK_ENTRIES);

  // input fields
  logic [9:0]  word_index;
  logic [15:0] word_value;
  logic [7:0]  code;
  assign word_index = s_tdata[9:0];
  assign word_value = s_tdata[25:10];
  assign code       = s_tdata[33:26];

  // configuration
  logic [1:0] pixel_format;
  logic       small_codebook;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format   <= vqtd_pkg::FMT_RGB565;
      small_codebook <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        vqtd_pkg::REG_PIXEL_FORMAT:   pixel_format   <= cfg_data;
        vqtd_pkg::REG_SMALL_CODEBOOK: small_codebook <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // captured decode request
  logic [7:0] code_q;
  logic       small_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      code_q  <= code;
      small_q <= small_codebook;
    end
  end

  // codebook access
  logic [7:0]    wentry, rentry;
  logic          we, rd_ok;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   rdata;

  assign wentry = word_index[9:2];
  assign we     = cmd.write && ({1'b0, wentry} < ENTRY_LIMIT);
  assign waddr  = word_index[AW-1:0];

  always_comb begin
    if (small_q) begin
      rentry = {4'b0000, (cmd.sel[2] ? code_q[7:4] : code_q[3:0])};
    end else begin
      rentry = code_q;
    end
  end
  assign rd_ok = ({1'b0, rentry} < ENTRY_LIMIT);
  assign raddr = {rentry[EW-1:0], cmd.sel[1:0]};

  vqtd_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_codebook (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(word_value),
    .re   (cmd.issue),
    .raddr(raddr),
    .rdata(rdata)
  );

  // read stage tags
  logic       rd_v;
  logic       rd_zero;
  logic       rd_last;
  logic [1:0] rd_row;
  logic       rd_column;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_zero   <= !rd_ok;
      rd_last   <= cmd.last;
      rd_row    <= {cmd.sel[2], cmd.sel[0]};
      rd_column <= cmd.sel[1];
    end
  end

  vqtd_pkg::texel_t push_texel;
  always_comb begin
    push_texel.last   = rd_last;
    push_texel.row    = rd_row;
    push_texel.column = rd_column;
    push_texel.rgb    = vqtd_pkg::expand(pixel_format, rd_zero ? 16'h0000 : rdata);
  end

  // two-entry output buffer
  vqtd_pkg::texel_t fifo [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;
  logic [2:0] occ;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != 2'd0);
  assign occ      = {1'b0, count} + {2'b00, rd_v} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (rd_v) begin
      fifo[wr_ptr] <= push_texel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (rd_v) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, rd_v} - {1'b0, pop};
    end
  end

  vqtd_pkg::texel_t head;
  assign head    = fifo[rd_ptr];
  assign m_tdata = {5'b00000, head.row, head.column, head.rgb.blue, head.rgb.green,
                    head.rgb.red};
  assign m_tlast = head.last;

  // room for one more read: buffered plus in flight stays at two
  assign stat.can_issue = (occ < 3'd2);
  assign stat.small_cb  = small_codebook;

  `VQTD_ASSERT_ALWAYS(a_count_max, count <= 2'd2, "output buffer count out of range")
  `VQTD_ASSERT_ALWAYS(a_no_overflow, ({1'b0, count} + {2'b00, rd_v}) <= 3'd2, "buffer overrun")
  `VQTD_ASSERT_NEXT(a_push_lands, rd_v, count != 2'd0, "texel lost on push")

endmodule
`default_nettype wire

[sv/vq_texture_decoder.sv]
// VQ texture decoder. A decode request is captured and its texels read one codebook
// word per cycle via the single RAM read port while the output buffer has room; no new
// request is taken until the code is done. Texels pass the RAM read register, then the buffer.
// A two-entry output buffer absorbs stalls. Synchronous reset sets RGB565 and normal
// codebook mode; codebook contents are not cleared.
`default_nettype none
module vq_texture_decoder #(
  parameter int CODEBOOK_ENTRIES = vqtd_pkg::CODEBOOK_ENTRIES_DEF
) (
  input  wire  logic                              clk,
  input  wire  logic                              rst,
  input  wire  logic                              s_tvalid,
  output logic                                    s_tready,
  // word_index[9:0], word_value[25:10], code[33:26], zero pad
  input  wire  logic [vqtd_pkg::IN_TDATA_W-1:0]   s_tdata,
  // mode
  input  wire  logic                              s_tuser,
  output logic                                    m_tvalid,
  input  wire  logic                              m_tready,
  // red[7:0], green[15:8], blue[23:16], column[24], row[26:25], zero pad
  output logic [vqtd_pkg::OUT_TDATA_W-1:0]        m_tdata,
  output logic                                    m_tlast,
  input  wire  logic                              cfg_valid,
  output logic                                    cfg_ready,
  input  wire  logic                              cfg_index,
  input  wire  logic [1:0]                        cfg_data
);

  vqtd_pkg::cmd_t  cmd;
  vqtd_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  vqtd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tuser (s_tuser),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  vqtd_datapath #(
    .CODEBOOK_ENTRIES(CODEBOOK_ENTRIES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

[dv/tb_vq_texture_decoder.sv]
// Self-checking testbench for vq_texture_decoder: codebook loads and code decodes on the
// stream ports, register writes between phases, texels checked against a local predictor.
// Depends on vqtd_pkg and the vq_texture_decoder RTL only.
`default_nettype none
module tb_vq_texture_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FMT_UNUSED = 2'd3;  // decodes as RGB565
  localparam int N_PHASES = 6;
  localparam int PHASE_ITEMS = 19;
  localparam int N_DIRECTED = 18;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [vqtd_pkg::IN_TDATA_W-1:0] s_tdata;   // word_index[9:0], word_value[25:10], code[33:26]
  logic s_tuser;                              // mode
  logic m_tvalid;
  logic m_tready;
  logic [vqtd_pkg::OUT_TDATA_W-1:0] m_tdata;  // red, green, blue bytes, column, row[26:25]
  logic m_tlast;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [1:0] cfg_data;

  vq_texture_decoder dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct packed {
    vqtd_pkg::rgb_t rgb;
    logic           column;
    logic [1:0]     row;
    logic           last;
  } texel_exp_t;

  // rgb4 holds four rrggbb texels, texel 0 in the low 24 bits
  typedef struct packed {
    logic        mode;
    logic [9:0]  idx;
    logic [15:0] val;
    logic [7:0]  code;
    logic        typed;
    logic [95:0] rgb4;
  } stim_row_t;

  texel_exp_t pending_texels[$];
  logic [63:0] book [256];
  logic [3:0] fill_mask [256];
  logic [7:0] full_entries[$];
  logic [7:0] full_low16[$];
  logic [1:0] cur_fmt;
  logic nibble_mode;

  int errors;
  int cycles;
  int loads_done;
  int codes_done;
  int texels_seen;
  bit tx_jitter;
  bit rx_jitter;
  bit hold_go;
  bit hold_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d texels outstanding", cycles,
               pending_texels.size());
      $display("tb_vq_texture_decoder NOT OK");
      $finish;
    end
  end

  function automatic vqtd_pkg::rgb_t texel_color(input logic [1:0] fmt,
                                                 input logic [15:0] c);
    vqtd_pkg::rgb_t o;
    logic [15:0] r, g, b;
    case (fmt)
      vqtd_pkg::FMT_ARGB1555: begin
        r = (c >> 7) & 16'h00f8;
        g = (c >> 2) & 16'h00f8;
        b = (c << 3) & 16'h00f8;
      end
      vqtd_pkg::FMT_ARGB4444: begin
        r = (c >> 4) & 16'h00f0;
        g = c & 16'h00f0;
        b = (c << 4) & 16'h00f0;
      end
      default: begin
        r = (c >> 8) & 16'h00f8;
        g = (c >> 3) & 16'h00fc;
        b = (c << 3) & 16'h00f8;
      end
    endcase
    o.red = r[7:0];
    o.green = g[7:0];
    o.blue = b[7:0];
    return o;
  endfunction

  function automatic void note_load(input logic [9:0] idx, input logic [15:0] val);
    logic [7:0] e;
    logic [3:0] was;
    e = idx[9:2];
    was = fill_mask[e];
    book[e][16*idx[1:0] +: 16] = val;
    fill_mask[e][idx[1:0]] = 1'b1;
    if (was != 4'hf && fill_mask[e] == 4'hf) begin
      full_entries.push_back(e);
      if (e < 16) full_low16.push_back(e);
    end
    loads_done++;
  endfunction

  function automatic void predict_entry(input logic [7:0] e, input logic [1:0] row_base,
                                        input logic ends);
    texel_exp_t x;
    for (int t = 0; t < 4; t++) begin
      x.rgb = texel_color(cur_fmt, book[e][16*t +: 16]);
      x.column = t[1];
      x.row = row_base + {1'b0, t[0]};
      x.last = ends && (t == 3);
      pending_texels.push_back(x);
    end
  endfunction

  function automatic void predict_code(input logic [7:0] code);
    if (nibble_mode) begin
      predict_entry({4'd0, code[3:0]}, 2'd0, 1'b0);
      predict_entry({4'd0, code[7:4]}, 2'd2, 1'b1);
    end else begin
      predict_entry(code, 2'd0, 1'b1);
    end
    codes_done++;
  endfunction

  // only codes whose entries are fully loaded
  function automatic logic [7:0] choose_code();
    logic [7:0] c;
    c = 8'($urandom);
    if (nibble_mode) begin
      if (fill_mask[c[3:0]] != 4'hf || fill_mask[c[7:4]] != 4'hf)
        c = {full_low16[$urandom_range(0, full_low16.size() - 1)][3:0],
             full_low16[$urandom_range(0, full_low16.size() - 1)][3:0]};
    end else if (fill_mask[c] != 4'hf) begin
      c = full_entries[$urandom_range(0, full_entries.size() - 1)];
    end
    return c;
  endfunction

  // leaves s_tvalid high after the accept; caller lowers it when the phase ends
  task automatic send_request(input logic mode, input logic [9:0] idx,
                              input logic [15:0] val, input logic [7:0] code);
    int gap;
    if (tx_jitter && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {6'd0, code, val, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == vqtd_pkg::REG_PIXEL_FORMAT) cur_fmt = value;
    else nibble_mode = value[0];
  endtask

  task automatic drain_and_settle();
    s_tvalid <= 1'b0;
    while (pending_texels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: random short stalls, plus one long hold to back the block up
  initial begin
    int stall;
    int hold;
    stall = 0;
    hold = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else if (rx_jitter && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(0, 3);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    texel_exp_t want;
    logic bad;
    if (!rst && m_tvalid && m_tready) begin
      texels_seen++;
      if (pending_texels.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected texel tdata=%h last=%b", $realtime, m_tdata, m_tlast);
      end else begin
        want = pending_texels.pop_front();
        bad = (m_tdata[7:0] != want.rgb.red) || (m_tdata[15:8] != want.rgb.green) ||
              (m_tdata[23:16] != want.rgb.blue) || (m_tdata[24] != want.column) ||
              (m_tdata[26:25] != want.row) || (m_tlast != want.last);
        if (bad) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: texel mismatch exp rgb=%h col=%b row=%0d last=%b",
                     $realtime, want.rgb, want.column, want.row, want.last);
            $display("  got rgb=%h%h%h col=%b row=%0d last=%b", m_tdata[7:0],
                     m_tdata[15:8], m_tdata[23:16], m_tdata[24], m_tdata[26:25], m_tlast);
          end
        end
      end
    end
  end

  initial begin
    stim_row_t dir_rows [N_DIRECTED];
    texel_exp_t x;
    logic [1:0] ph_fmt [N_PHASES];
    logic ph_nib [N_PHASES];
    logic [7:0] e;
    logic [7:0] c;
    logic [9:0] widx;
    logic [15:0] wval;
    int sent;
    int pick;

    dir_rows = '{
      '{vqtd_pkg::MODE_LOAD,   10'd0,    16'h0000, 8'hff, 1'b0, 96'h0},
      '{vqtd_pkg::MODE_LOAD,   10'd1,    16'h0000, 8'h00, 1'b0, 96'h0},
      '{vqtd_pkg::MODE_LOAD,   10'd2,    16'h0000, 8'h00, 1'b0, 96'h0},
      '{vqtd_pkg::MODE_LOAD,   10'd3,    16'h0000, 8'h00, 1'b0, 96'h0},
      '{vqtd_pkg::MODE_LOAD,   10'd1020, 16'hffff, 8'h00, 1'b0, 96'h0},
      '{vqtd_pkg::MODE_LOAD,   10'd1021, 16'hffff, 8'h00, 1'b0, 96'h0},
      '{vqtd_pkg::MODE_LOAD,   10'd1022, 16'hffff, 8'h00, 1'b0, 96'h0},
      '{vqtd_pkg::MODE_LOAD,   10'd1023, 16'hffff, 8'hff, 1'b0, 96'h0},
      '{vqtd_pkg::MODE_LOAD,   10'd60,   16'hf800, 8'h00, 1'b0, 96'h0},
      '{vqtd_pkg::MODE_LOAD,   10'd61,   16'h07e0, 8'h00, 1'b0, 96'h0},
      '{vqtd_pkg::MODE_LOAD,   10'd62,   16'h001f, 8'h00, 1'b0, 96'h0},
      '{vqtd_pkg::MODE_LOAD,   10'd63,   16'hffff, 8'h00, 1'b0, 96'h0},
      '{vqtd_pkg::MODE_DECODE, 10'd0,    16'h0000, 8'h00, 1'b1, 96'h0},
      '{vqtd_pkg::MODE_DECODE, 10'd0,    16'h0000, 8'hff, 1'b1, {4{24'hf8fcf8}}},
      '{vqtd_pkg::MODE_DECODE, 10'd0,    16'h0000, 8'h0f, 1'b1,
        {24'hf8fcf8, 24'h0000f8, 24'h00fc00, 24'hf80000}},
      '{vqtd_pkg::MODE_LOAD,   10'd2,    16'h5a5a, 8'h3c, 1'b0, 96'h0},
      '{vqtd_pkg::MODE_DECODE, 10'd1023, 16'hffff, 8'h00, 1'b0, 96'h0},
      '{vqtd_pkg::MODE_DECODE, 10'd1023, 16'hffff, 8'h0f, 1'b0, 96'h0}
    };
    ph_fmt = '{vqtd_pkg::FMT_ARGB1555, vqtd_pkg::FMT_ARGB4444, FMT_UNUSED,
               vqtd_pkg::FMT_RGB565, vqtd_pkg::FMT_ARGB4444, vqtd_pkg::FMT_ARGB1555};
    ph_nib = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    for (int i = 0; i < 256; i++) begin
      fill_mask[i] = 4'h0;
      book[i] = 64'h0;
    end
    errors = 0;
    cycles = 0;
    loads_done = 0;
    codes_done = 0;
    texels_seen = 0;
    hold_go = 1'b0;
    hold_done = 1'b0;
    cur_fmt = vqtd_pkg::FMT_RGB565;
    nibble_mode = 1'b0;
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = vqtd_pkg::MODE_LOAD;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = vqtd_pkg::REG_PIXEL_FORMAT;
    cfg_data = 2'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part under the reset settings: RGB565, one code per byte
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_request(dir_rows[i].mode, dir_rows[i].idx, dir_rows[i].val, dir_rows[i].code);
      if (dir_rows[i].mode == vqtd_pkg::MODE_LOAD) begin
        note_load(dir_rows[i].idx, dir_rows[i].val);
      end else if (dir_rows[i].typed) begin
        for (int t = 0; t < 4; t++) begin
          x.rgb = dir_rows[i].rgb4[24*t +: 24];
          x.column = t[1];
          x.row = {1'b0, t[0]};
          x.last = (t == 3);
          pending_texels.push_back(x);
        end
        codes_done++;
      end else begin
        predict_code(dir_rows[i].code);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain_and_settle();
      write_reg(vqtd_pkg::REG_PIXEL_FORMAT, ph_fmt[p]);
      write_reg(vqtd_pkg::REG_SMALL_CODEBOOK, {1'b0, ph_nib[p]});
      cfg_valid <= 1'b0;
      tx_jitter = (p < N_PHASES - 1) && ($urandom_range(0, 3) != 0);
      rx_jitter = (p < N_PHASES - 1) && ($urandom_range(0, 3) != 0);
      if (p == 1) hold_go = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
          // fill one whole entry, low entries favored in nibble mode
          e = (nibble_mode && $urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 15))
                                                         : 8'($urandom_range(0, 255));
          for (int t = 0; t < 4; t++) begin
            widx = {e, t[1:0]};
            wval = 16'($urandom);
            send_request(vqtd_pkg::MODE_LOAD, widx, wval, 8'($urandom));
            note_load(widx, wval);
          end
          sent += 4;
        end else if (pick == 3) begin
          widx = 10'($urandom);
          wval = 16'($urandom);
          send_request(vqtd_pkg::MODE_LOAD, widx, wval, 8'($urandom));
          note_load(widx, wval);
          sent++;
        end else begin
          c = choose_code();
          send_request(vqtd_pkg::MODE_DECODE, 10'($urandom), 16'($urandom), c);
          predict_code(c);
          sent++;
        end
      end
    end

    drain_and_settle();
    $display("covered %0d codebook loads and %0d decodes, %0d texels checked,",
             loads_done, codes_done, texels_seen);
    $display("every format code incl. the unused one, both codebook modes, %0d errors",
             errors);
    if (errors == 0) begin
      $display("tb_vq_texture_decoder OK");
    end else begin
      $display("tb_vq_texture_decoder NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
